>>> rtl/skrl_pkg.sv
// ----------------------------------------------------------------------------
// skrl_pkg: shared types and constants for the sorted key run lookup
// Field widths, opcodes, result kinds and the default table depth.
// ----------------------------------------------------------------------------
package skrl_pkg;

   localparam int KEY_W  = 16;
   localparam int VAL_W  = 9;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int KIND_W = 2;

   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam logic [IDX_W-1:0] NO_MATCH_VALUE = 10'h1FF;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE    = 2'd0,
      KIND_SINGLE  = 2'd1,
      KIND_SEVERAL = 2'd2
   } match_kind_type;

endpackage

>>> rtl/skrl_ram.sv
// ----------------------------------------------------------------------------
// skrl_ram: generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module skrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sorted_key_run_lookup_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_run_lookup_unit: binary search with equal-key run widening
// Sorted key/value table in one RAM, searched by a small sequencer.
// ----------------------------------------------------------------------------
// A load transaction writes one key/value entry unless its index lies beyond
// the table. A query transaction binary-searches the first csr_wr_data
// entries (clamped to the table depth) and then walks down and up from the
// hit to cover the whole run of equal keys. Probes and neighbor reads share
// the single RAM port: a query is accepted, makes at most ceil(log2(count+1))
// probes (11 for a full 1024-entry table) and at most run length + 1 neighbor
// reads, and then registers its result. An empty table skips the search and
// goes straight to the result. A query is accepted only when the result
// register is free or being emptied in the same cycle; loads are accepted
// whenever the sequencer is idle.
module sorted_key_run_lookup_unit
   import skrl_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   input  logic [IDX_W-1:0]     req_entry_index,
   input  logic [KEY_W-1:0]     req_search_key,
   input  logic [VAL_W-1:0]     req_entry_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KIND_W-1:0]    rsp_match_kind,
   output logic [IDX_W-1:0]     rsp_value_or_first_index,
   output logic [CNT_W-1:0]     rsp_run_length,
   input  logic                 csr_wr_en,
   input  logic [CNT_W-1:0]     csr_wr_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int PW = AW + 1;
   localparam int CW = (PW > CNT_W) ? PW : CNT_W;
   localparam int XW = (AW > IDX_W) ? AW : IDX_W;
   localparam int EW = KEY_W + VAL_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,
      S_DOWN,
      S_UP,
      S_FIN
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PW-1:0]       lo_ff, lo_in;
   logic [PW-1:0]       hx_ff, hx_in;
   logic [PW-1:0]       addr_ff, addr_in;
   logic [PW-1:0]       first_ff, first_in;
   logic [PW-1:0]       last_ff, last_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VAL_W-1:0]    val_ff, val_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [IDX_W-1:0]    voi_ff, voi_in;
   logic [CNT_W-1:0]    run_ff, run_in;

   logic                req_fire;
   logic [CW-1:0]       count_wide;
   logic [CW-1:0]       live_wide;
   logic [PW-1:0]       live_cnt;
   logic                idx_ok;
   logic [XW-1:0]       idx_wide;
   logic                wr_en;
   logic [PW-1:0]       rd_addr;
   logic [AW-1:0]       ram_addr;
   logic [EW-1:0]       ram_rd_data;
   logic [KEY_W-1:0]    rd_key;
   logic [VAL_W-1:0]    rd_val;
   logic                key_eq;
   logic                key_lt;
   logic [PW-1:0]       lo_next;
   logic [PW-1:0]       hx_next;
   logic [PW:0]         mid_sum;
   logic [PW-1:0]       run_len;
   logic [CW-1:0]       first_wide;
   logic [CW-1:0]       run_wide;

   // Clamp the entry count to the table depth.
   assign count_wide = CW'(count_ff);
   assign live_wide  = (count_wide > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : count_wide;
   assign live_cnt   = live_wide[PW-1:0];

   assign idx_ok   = CW'(req_entry_index) < CW'(TABLE_DEPTH);
   assign idx_wide = XW'(req_entry_index);

   assign req_ready = (state_ff == S_IDLE) &&
                      ((req_opcode == OP_LOAD) || !rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   assign rd_key = ram_rd_data[EW-1:VAL_W];
   assign rd_val = ram_rd_data[VAL_W-1:0];
   assign key_eq = (rd_key == key_ff);
   assign key_lt = (key_ff < rd_key);

   assign ram_addr = wr_en ? idx_wide[AW-1:0] : rd_addr[AW-1:0];

   skrl_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (ram_addr),
      .wr_data ({req_search_key, req_entry_value}),
      .rd_data (ram_rd_data)
   );

   // Interval bounds after the current probe, half-open [lo, hx).
   always_comb begin
      lo_next = lo_ff;
      hx_next = hx_ff;
      if (key_lt) begin
         hx_next = addr_ff;
      end else begin
         lo_next = addr_ff + PW'(1);
      end
      mid_sum = {1'b0, lo_next} + {1'b0, hx_next} - (PW + 1)'(1);
   end

   assign run_len    = last_ff - first_ff + PW'(1);
   assign first_wide = CW'(first_ff);
   assign run_wide   = CW'(run_len);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hx_in        = hx_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      hit_in       = hit_ff;
      kind_in      = kind_ff;
      voi_in       = voi_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      rd_addr      = addr_ff;

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_opcode == OP_LOAD) begin
                  wr_en = idx_ok;
               end else begin
                  key_in = req_search_key;
                  hit_in = 1'b0;
                  if (live_cnt == '0) begin
                     state_in = S_FIN;
                  end else begin
                     lo_in    = '0;
                     hx_in    = live_cnt;
                     rd_addr  = (live_cnt - PW'(1)) >> 1;
                     state_in = S_PROBE;
                  end
               end
            end
         end

         S_PROBE: begin
            if (key_eq) begin
               hit_in   = 1'b1;
               first_in = addr_ff;
               last_in  = addr_ff;
               val_in   = rd_val;
               if (addr_ff != '0) begin
                  rd_addr  = addr_ff - PW'(1);
                  state_in = S_DOWN;
               end else if (addr_ff + PW'(1) < live_cnt) begin
                  rd_addr  = addr_ff + PW'(1);
                  state_in = S_UP;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               lo_in = lo_next;
               hx_in = hx_next;
               if (lo_next < hx_next) begin
                  rd_addr = mid_sum[PW:1];
               end else begin
                  state_in = S_FIN;
               end
            end
         end

         S_DOWN: begin
            if (key_eq && (addr_ff != '0)) begin
               first_in = addr_ff;
               rd_addr  = addr_ff - PW'(1);
            end else begin
               if (key_eq) begin
                  first_in = addr_ff;
               end
               // Run start settled; scan upward unless the run ends at the last live entry.
               if (last_ff + PW'(1) < live_cnt) begin
                  rd_addr  = last_ff + PW'(1);
                  state_in = S_UP;
               end else begin
                  state_in = S_FIN;
               end
            end
         end

         S_UP: begin
            if (key_eq) begin
               last_in = addr_ff;
               if (addr_ff + PW'(1) < live_cnt) begin
                  rd_addr = addr_ff + PW'(1);
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            rsp_valid_in = 1'b1;
            if (!hit_ff) begin
               kind_in = KIND_NONE;
               voi_in  = NO_MATCH_VALUE;
               run_in  = '0;
            end else if (run_len == PW'(1)) begin
               kind_in = KIND_SINGLE;
               voi_in  = IDX_W'(val_ff);
               run_in  = CNT_W'(1);
            end else begin
               kind_in = KIND_SEVERAL;
               voi_in  = first_wide[IDX_W-1:0];
               run_in  = run_wide[CNT_W-1:0];
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      addr_in = rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
      end
      lo_ff    <= lo_in;
      hx_ff    <= hx_in;
      addr_ff  <= addr_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      key_ff   <= key_in;
      val_ff   <= val_in;
      kind_ff  <= kind_in;
      voi_ff   <= voi_in;
      run_ff   <= run_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_match_kind           = kind_ff;
   assign rsp_value_or_first_index = voi_ff;
   assign rsp_run_length           = run_ff;

`ifndef SYNTHESIS
   // The result register must be empty whenever a query result is written.
   a_fin_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> !rsp_valid_ff)
      else $error("result register still full when a query finished");

   // The pending probe address stays inside the live search interval.
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> ((lo_ff <= addr_ff) && (addr_ff < hx_ff)))
      else $error("probe address outside the search interval");

   // Run scans only follow a hit and keep the run bounds ordered.
   a_scan_after_hit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DOWN) || (state_ff == S_UP)) |-> (hit_ff && (first_ff <= last_ff)))
      else $error("run scan without a hit or with reversed bounds");
`endif

endmodule
